/* rtl/core/mm4_pkg.sv */
`default_nettype none
package mm4_pkg;

	localparam int Lanes = 4;
	localparam int Cols = 4;
	localparam int Depth = 7;
	localparam logic [31:0] QNAN = 32'h7FC0_0000;
	localparam logic [31:0] EXP_MASK = 32'h7F80_0000;

	typedef logic [31:0] word_t;

	// Operation carried in tuser.
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_MUL  = 1'b1
	} op_t;

	// An operation before rounding: either a finished special value or sig * 2^e.
	typedef struct packed {
		logic               spec;
		logic [31:0]        val;
		logic               sign;
		logic signed [11:0] e;
		logic [63:0]        sig;
	} pre_t;

	typedef struct packed {
		logic en;
	} lane_ctl_t;

	function automatic logic is_nan(input logic [31:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] != '0);
	endfunction

	function automatic logic is_inf(input logic [31:0] x);
		return x[30:0] == EXP_MASK[30:0];
	endfunction

	function automatic logic is_zero(input logic [31:0] x);
		return x[30:0] == '0;
	endfunction

	function automatic logic [23:0] unpack_sig(input logic [31:0] x);
		return (x[30:23] == 8'h00) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
	endfunction

	function automatic logic signed [11:0] unpack_exp(input logic [31:0] x);
		return (x[30:23] == 8'h00) ? -12'sd149 : $signed({4'b0, x[30:23]}) - 12'sd150;
	endfunction

	// Rounds sig * 2^e to binary32, nearest even, with gradual underflow.
	function automatic logic [31:0] pack_round(input logic sign, input logic signed [11:0] e,
			input logic [63:0] sig);
		logic [5:0]         p;
		logic signed [12:0] sh;
		logic signed [12:0] lim;
		logic [63:0]        m;
		logic [63:0]        rem;
		logic [63:0]        half;
		logic [63:0]        msk;
		logic signed [13:0] field;
		logic [33:0]        total;
		logic [31:0]        res;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (sig[i]) begin
				p = 6'(i);
			end
		end
		sh = $signed({7'b0, p}) - 13'sd23;
		lim = -13'sd149 - 13'(e);
		if (lim > sh) begin
			sh = lim;
		end
		if (sh <= 13'sd0) begin
			m = sig << 6'(-sh);
		end else if (sh >= 13'sd64) begin
			m = '0;
		end else begin
			msk = (64'd1 << 6'(sh)) - 64'd1;
			rem = sig & msk;
			half = 64'd1 << 6'(sh - 13'sd1);
			m = sig >> 6'(sh);
			if (rem > half || (rem == half && m[0])) begin
				m = m + 64'd1;
			end
		end
		field = 14'(e) + 14'(sh) + 14'sd149;
		total = 34'({field[7:0], 23'b0}) + m[33:0];
		if (field >= 14'sd255 || total >= 34'(EXP_MASK)) begin
			res = {sign, EXP_MASK[30:0]};
		end else begin
			res = {sign, total[30:0]};
		end
		return res;
	endfunction

	function automatic logic [31:0] finish(input pre_t x);
		return x.spec ? x.val : pack_round(x.sign, x.e, x.sig);
	endfunction

	function automatic pre_t mul_pre(input logic [31:0] a, input logic [31:0] b);
		pre_t r;
		r.sign = a[31] ^ b[31];
		r.spec = 1'b1;
		r.val = '0;
		r.e = unpack_exp(a) + unpack_exp(b);
		r.sig = 64'(48'(unpack_sig(a)) * 48'(unpack_sig(b)));
		if (is_nan(a) || is_nan(b)) begin
			r.val = QNAN;
		end else if (is_inf(a) || is_inf(b)) begin
			r.val = (is_zero(a) || is_zero(b)) ? QNAN : {r.sign, EXP_MASK[30:0]};
		end else if (is_zero(a) || is_zero(b)) begin
			r.val = {r.sign, 31'b0};
		end else begin
			r.spec = 1'b0;
		end
		return r;
	endfunction

	function automatic pre_t add_pre(input logic [31:0] a, input logic [31:0] b);
		pre_t               r;
		logic [31:0]        hi;
		logic [31:0]        lo;
		logic signed [11:0] ea;
		logic signed [11:0] eb;
		logic [8:0]         diff;
		logic [63:0]        ma;
		logic [63:0]        mb;
		logic [63:0]        full;
		if (unpack_exp(a) < unpack_exp(b)) begin
			hi = b;
			lo = a;
		end else begin
			hi = a;
			lo = b;
		end
		ea = unpack_exp(hi);
		eb = unpack_exp(lo);
		diff = 9'(ea - eb);
		ma = {2'b0, unpack_sig(hi), 38'b0};
		full = {2'b0, unpack_sig(lo), 38'b0};
		if (diff >= 9'd62) begin
			mb = 64'd1;
		end else begin
			mb = full >> diff[5:0];
			if ((full & ((64'd1 << diff[5:0]) - 64'd1)) != '0) begin
				mb[0] = 1'b1;
			end
		end
		r.e = ea - 12'sd38;
		if (hi[31] == lo[31]) begin
			r.sig = ma + mb;
			r.sign = hi[31];
		end else if (ma >= mb) begin
			r.sig = ma - mb;
			r.sign = hi[31];
		end else begin
			r.sig = mb - ma;
			r.sign = lo[31];
		end
		r.spec = 1'b1;
		r.val = '0;
		if (is_nan(a) || is_nan(b)) begin
			r.val = QNAN;
		end else if (is_inf(a) && is_inf(b)) begin
			r.val = (a[31] == b[31]) ? a : QNAN;
		end else if (is_inf(a)) begin
			r.val = a;
		end else if (is_inf(b)) begin
			r.val = b;
		end else if (is_zero(a) && is_zero(b)) begin
			r.val = {a[31] & b[31], 31'b0};
		end else if (is_zero(a)) begin
			r.val = b;
		end else if (is_zero(b)) begin
			r.val = a;
		end else if (r.sig == '0) begin
			r.val = '0;
		end else begin
			r.spec = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/mm4_lane.sv */
`default_nettype none
module mm4_lane
	import mm4_pkg::*;
(
	input  wire logic      clk,
	input  wire lane_ctl_t ctl,
	input  wire word_t     a [Cols],
	input  wire word_t     b [Cols],
	output word_t          res
);

	pre_t  mul_s1 [Cols];
	word_t prod_s2 [Cols];
	pre_t  add_s3;
	word_t p2_s3, p3_s3;
	word_t sum_s4, p2_s4, p3_s4;
	pre_t  add_s5;
	word_t p3_s5;
	word_t sum_s6, p3_s6;
	pre_t  add_s7;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int k = 0; k < Cols; k++) begin
				mul_s1[k] <= mul_pre(a[k], b[k]);
				prod_s2[k] <= finish(mul_s1[k]);
			end
			add_s3 <= add_pre(prod_s2[0], prod_s2[1]);
			p2_s3 <= prod_s2[2];
			p3_s3 <= prod_s2[3];
			sum_s4 <= finish(add_s3);
			p2_s4 <= p2_s3;
			p3_s4 <= p3_s3;
			add_s5 <= add_pre(sum_s4, p2_s4);
			p3_s5 <= p3_s4;
			sum_s6 <= finish(add_s5);
			p3_s6 <= p3_s5;
			add_s7 <= add_pre(sum_s6, p3_s6);
		end
	end

	assign res = finish(add_s7);

endmodule
`default_nettype wire

/* rtl/core/matrix4x4_column_transform.sv */
// Four row lanes each run a 7-stage multiply-add chain that feeds the output register.
// Throughput: one item per cycle while the result is not stalled.
// A stalled result holds the whole pipeline and the input until it is taken.
// A load item writes the stored left matrix at acceptance and gives no result.
// Reset clears all valid flags; the stored left matrix holds no reset value.
`default_nettype none
module matrix4x4_column_transform
	import mm4_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [135:0] s_axis_tdata,  // column[1:0], elem_0, elem_1, elem_2, elem_3, zeros
	input  wire logic         s_axis_tuser,  // op
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [135:0]      m_axis_tdata   // res_column[1:0], res_0, res_1, res_2, res_3, zeros
);

	word_t      lm_q [Cols][Lanes];
	word_t      elem [Cols];
	word_t      lane_a [Lanes][Cols];
	word_t      lane_res [Lanes];
	logic [1:0] column;
	logic       accept;
	lane_ctl_t  ctl;
	logic [Depth-1:0] vld_q;
	logic [1:0]       col_q [Depth];
	logic [1:0]       out_col_q;
	word_t            out_res_q [Lanes];

	assign column = s_axis_tdata[1:0];
	assign ctl.en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ctl.en;
	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		for (int k = 0; k < Cols; k++) begin
			elem[k] = s_axis_tdata[2 + 32*k +: 32];
			for (int r = 0; r < Lanes; r++) begin
				lane_a[r][k] = lm_q[k][r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op_t'(s_axis_tuser) == OP_LOAD) begin
			for (int r = 0; r < Lanes; r++) begin
				lm_q[column][r] <= elem[r];
			end
		end
	end

	for (genvar r = 0; r < Lanes; r++) begin : g_lane
		mm4_lane u_lane (
			.clk(clk),
			.ctl(ctl),
			.a  (lane_a[r]),
			.b  (elem),
			.res(lane_res[r])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (ctl.en) begin
			vld_q <= {vld_q[Depth-2:0], accept && op_t'(s_axis_tuser) == OP_MUL};
			m_axis_tvalid <= vld_q[Depth-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			col_q[0] <= column;
			for (int i = 1; i < Depth; i++) begin
				col_q[i] <= col_q[i-1];
			end
			out_col_q <= col_q[Depth-1];
			out_res_q <= lane_res;
		end
	end

	assign m_axis_tdata = {6'b0, out_res_q[3], out_res_q[2], out_res_q[1], out_res_q[0],
		out_col_q};

endmodule
`default_nettype wire

/* rtl/core/mm4_checker.sv */
`default_nettype none
module mm4_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic [135:0] s_axis_tdata,
	input wire logic         s_axis_tuser,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [135:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow the output register");

	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !m_axis_tvalid)
		else $error("result right after reset");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[135:130] == 6'b0)
		else $error("padding bits set");

endmodule

bind matrix4x4_column_transform mm4_checker u_chk (.*);
`default_nettype wire

/* bench/matrix4x4_column_transform_tb.sv */
module matrix4x4_column_transform_tb;
	import mm4_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit = 5000;
	localparam int HoldCycles = 400;
	localparam int Latency = 8;
	localparam logic [31:0] POS_INF = 32'h7F80_0000;
	localparam logic [31:0] NEG_INF = 32'hFF80_0000;
	localparam logic [31:0] ONE = 32'h3F80_0000;
	localparam logic [31:0] NEG_ONE = 32'hBF80_0000;
	localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
	localparam logic [31:0] MAX_FIN = 32'h7F7F_FFFF;
	localparam logic [31:0] MIN_SUB = 32'h0000_0001;
	localparam logic [31:0] MIN_NORM = 32'h0080_0000;

	typedef logic [3:0][31:0] column_t;
	typedef struct packed {
		logic [1:0] col;
		column_t    rows;
	} product_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;
	op_t          s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [135:0] m_axis_tdata;

	column_t  left_cols [4];
	product_t product_q [$];
	int       mismatches = 0;
	int       burst_left = 0;
	bit       no_gaps = 0;
	bit       hold_req = 0;
	int       idle_cycles = 0;
	int       items_sent = 0;

	matrix4x4_column_transform i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int top_bit(input logic [63:0] v);
		int p;
		p = 0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				p = i;
			end
		end
		return p;
	endfunction

	function automatic word_t fp_round(input logic sign, input int e, input logic [63:0] sig);
		int          shift;
		logic [63:0] m;
		logic [63:0] rem;
		logic [63:0] half;
		longint      field;
		logic [63:0] total;
		shift = top_bit(sig) - 23;
		if (-149 - e > shift) begin
			shift = -149 - e;
		end
		if (shift <= 0) begin
			m = sig << (-shift);
		end else if (shift >= 64) begin
			m = (shift == 64 && sig > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
		end else begin
			rem = sig & ((64'd1 << shift) - 64'd1);
			half = 64'd1 << (shift - 1);
			m = sig >> shift;
			if (rem > half || (rem == half && m[0])) begin
				m = m + 64'd1;
			end
		end
		field = longint'(e) + shift + 149;
		if (field >= 255) begin
			return {sign, POS_INF[30:0]};
		end
		total = (64'(field) << 23) + m;
		if (total >= 64'(POS_INF)) begin
			return {sign, POS_INF[30:0]};
		end
		return {sign, total[30:0]};
	endfunction

	function automatic void split_float(input word_t x, output logic [63:0] sig, output int e);
		if (x[30:23] == 8'h00) begin
			sig = {41'b0, x[22:0]};
			e = -149;
		end else begin
			sig = {40'b0, 1'b1, x[22:0]};
			e = int'(x[30:23]) - 150;
		end
	endfunction

	function automatic bit f_nan(input word_t x);
		return x[30:23] == 8'hFF && x[22:0] != '0;
	endfunction

	function automatic bit f_inf(input word_t x);
		return x[30:0] == POS_INF[30:0];
	endfunction

	function automatic bit f_zero(input word_t x);
		return x[30:0] == '0;
	endfunction

	function automatic word_t fp_mul(input word_t a, input word_t b);
		logic        s;
		logic [63:0] sa;
		logic [63:0] sb;
		int          ea;
		int          eb;
		s = a[31] ^ b[31];
		if (f_nan(a) || f_nan(b)) begin
			return QNAN;
		end
		if (f_inf(a) || f_inf(b)) begin
			return (f_zero(a) || f_zero(b)) ? QNAN : {s, POS_INF[30:0]};
		end
		if (f_zero(a) || f_zero(b)) begin
			return {s, 31'b0};
		end
		split_float(a, sa, ea);
		split_float(b, sb, eb);
		return fp_round(s, ea + eb, sa * sb);
	endfunction

	function automatic word_t fp_add(input word_t a, input word_t b);
		word_t       hi;
		word_t       lo;
		logic [63:0] xa;
		logic [63:0] xb;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] full;
		logic [63:0] r;
		int          ea;
		int          eb;
		int          diff;
		logic        sr;
		if (f_nan(a) || f_nan(b)) begin
			return QNAN;
		end
		if (f_inf(a) && f_inf(b)) begin
			return (a[31] == b[31]) ? a : QNAN;
		end
		if (f_inf(a)) begin
			return a;
		end
		if (f_inf(b)) begin
			return b;
		end
		if (f_zero(a) && f_zero(b)) begin
			return {a[31] & b[31], 31'b0};
		end
		if (f_zero(a)) begin
			return b;
		end
		if (f_zero(b)) begin
			return a;
		end
		split_float(a, xa, ea);
		split_float(b, xb, eb);
		hi = a;
		lo = b;
		if (ea < eb) begin
			hi = b;
			lo = a;
			split_float(hi, xa, ea);
			split_float(lo, xb, eb);
		end
		diff = ea - eb;
		ma = xa << 38;
		if (diff >= 62) begin
			mb = 64'd1;
		end else begin
			full = xb << 38;
			mb = full >> diff;
			if ((mb << diff) != full) begin
				mb[0] = 1'b1;
			end
		end
		if (hi[31] == lo[31]) begin
			r = ma + mb;
			sr = hi[31];
		end else if (ma >= mb) begin
			r = ma - mb;
			sr = hi[31];
		end else begin
			r = mb - ma;
			sr = lo[31];
		end
		if (r == '0) begin
			return '0;
		end
		return fp_round(sr, ea - 38, r);
	endfunction

	function automatic product_t column_product(input logic [1:0] col, input column_t b);
		product_t p;
		word_t    acc;
		p.col = col;
		for (int r = 0; r < 4; r++) begin
			acc = fp_mul(left_cols[0][r], b[0]);
			for (int k = 1; k < 4; k++) begin
				acc = fp_add(acc, fp_mul(left_cols[k][r], b[k]));
			end
			p.rows[r] = acc;
		end
		return p;
	endfunction

	function automatic word_t pick_float();
		word_t v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 7))
					0: v = '0;
					1: v = NEG_ZERO;
					2: v = POS_INF;
					3: v = NEG_INF;
					4: v = {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
					5: v = {$urandom_range(0, 1) == 1, MAX_FIN[30:0]};
					6: v = {$urandom_range(0, 1) == 1, MIN_SUB[30:0]};
					default: v = {$urandom_range(0, 1) == 1, MIN_NORM[30:0]};
				endcase
			end
			1, 2, 3, 4: v[30:23] = 8'($urandom_range(118, 136));
			5: v[30:23] = 8'h00;
			6: v[30:23] = 8'($urandom_range(1, 20));
			7: v[30:23] = 8'($urandom_range(200, 254));
			default: ;
		endcase
		return v;
	endfunction

	function automatic column_t pick_column();
		column_t c;
		for (int i = 0; i < 4; i++) begin
			c[i] = pick_float();
		end
		return c;
	endfunction

	task automatic send_item(input op_t op, input logic [1:0] col, input column_t b);
		int gap;
		if (burst_left == 0 && !no_gaps) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'b0, b[3], b[2], b[1], b[0], col};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		items_sent++;
		if (op == OP_LOAD) begin
			left_cols[col] = b;
		end else begin
			product_q.push_back(column_product(col, b));
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (product_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] expected,
			input logic [31:0] got);
		$display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, expected, got);
		mismatches++;
	endtask

	task automatic test_directed_specials();
		send_item(OP_LOAD, 2'd0, {MIN_SUB, MAX_FIN, NEG_ZERO, ONE});
		send_item(OP_LOAD, 2'd1, {32'hFFFF_FFFF, MIN_NORM, POS_INF, NEG_INF});
		send_item(OP_LOAD, 2'd2, {ONE, 32'h007F_FFFF, NEG_ONE, 32'h4000_0000});
		send_item(OP_LOAD, 2'd3, {32'hC000_0000, NEG_ZERO, ONE, ONE});
		send_item(OP_MUL, 2'd0, {32'h0, 32'h0, 32'h0, ONE});
		send_item(OP_MUL, 2'd1, {32'h0, 32'h0, ONE, 32'h0});
		send_item(OP_MUL, 2'd2, {32'h0, ONE, 32'h0, 32'h0});
		send_item(OP_MUL, 2'd3, {ONE, 32'h0, 32'h0, 32'h0});
		send_item(OP_MUL, 2'd0, {NEG_ZERO, NEG_ZERO, 32'h0, NEG_ZERO});
		send_item(OP_MUL, 2'd1, {32'h7FC1_2345, ONE, ONE, ONE});
		send_item(OP_MUL, 2'd2, {ONE, ONE, ONE, ONE});
		send_item(OP_MUL, 2'd3, {MAX_FIN, MAX_FIN, 32'h0, MAX_FIN});
		send_item(OP_MUL, 2'd0, {MIN_SUB, MIN_SUB, MIN_SUB, 32'h3F00_0000});
		send_item(OP_LOAD, 2'd0, {32'h0, 32'h0, ONE, ONE});
		send_item(OP_LOAD, 2'd1, {32'h0, 32'h0, NEG_ONE, NEG_ONE});
		send_item(OP_MUL, 2'd3, {32'h0, 32'h0, ONE, ONE});
		send_item(OP_MUL, 2'd2, {32'h0, 32'h0, NEG_ZERO, 32'h0});
		send_item(OP_LOAD, 2'd3, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_item(OP_MUL, 2'd1, {32'hFFFF_FFFF, MAX_FIN, NEG_INF, POS_INF});
		send_item(OP_LOAD, 2'd2, {MAX_FIN, MAX_FIN, MAX_FIN, MAX_FIN});
		send_item(OP_MUL, 2'd3, {32'h7F00_0000, 32'h7F00_0000, 32'h7F00_0000, 32'h7F00_0000});
	endtask

	task automatic test_random_streams();
		int n;
		while (items_sent < 470) begin
			n = $urandom_range(0, 4);
			repeat (n) begin
				send_item(OP_LOAD, 2'($urandom_range(0, 3)), pick_column());
			end
			n = $urandom_range(1, 5);
			repeat (n) begin
				send_item(OP_MUL, 2'($urandom_range(0, 3)), pick_column());
			end
		end
	endtask

	task automatic test_output_stall_fill();
		no_gaps = 1'b1;
		hold_req = 1'b1;
		repeat (40) begin
			send_item(OP_MUL, 2'($urandom_range(0, 3)), pick_column());
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_drain_then_reload();
		wait_drained();
		for (int c = 0; c < 4; c++) begin
			send_item(OP_LOAD, 2'(c), pick_column());
		end
		repeat (12) begin
			send_item(OP_MUL, 2'($urandom_range(0, 3)), pick_column());
		end
	endtask

	initial begin
		int mode;
		int left;
		m_axis_tready = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(10, 60);
				end
				left--;
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= $urandom_range(0, 1) == 1;
					2: m_axis_tready <= $urandom_range(0, 3) == 0;
					default: m_axis_tready <= left[0];
				endcase
			end
		end
	end

	always @(posedge clk) begin
		product_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (product_q.size() == 0) begin
				report_mismatch("unexpected result column", '0, 32'(m_axis_tdata[1:0]));
			end else begin
				want = product_q.pop_front();
				if (m_axis_tdata[1:0] != want.col) begin
					report_mismatch("res_column", 32'(want.col), 32'(m_axis_tdata[1:0]));
				end
				for (int r = 0; r < 4; r++) begin
					if (m_axis_tdata[2 + 32 * r +: 32] !== want.rows[r]) begin
						report_mismatch($sformatf("res_%0d", r), want.rows[r],
							m_axis_tdata[2 + 32 * r +: 32]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IdleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = OP_LOAD;
		s_axis_tdata = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_directed_specials();
		test_random_streams();
		test_output_stall_fill();
		test_drain_then_reload();
		wait_drained();
		repeat (Latency * 4) @(negedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
